### src/ale_pkg.sv
// ============================================================================
// ale_pkg
// Shared constants, codes and controller/datapath bundles of the list engine.
// ============================================================================
package ale_pkg;

    localparam int DEPTH   = 64;
    localparam int WIDTH   = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int FOUND_W = 6;
    localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4,
        OP_FIND   = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_COUNT,
        CUR_POS_INC,
        CUR_ZERO
    } t_cur_sel;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_DOWN,
        STEP_UP,
        STEP_SCAN
    } t_step;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_AT_COUNT,
        WR_AT_POS,
        WR_SHIFT
    } t_wr_sel;

    typedef struct packed {
        logic     load;
        t_cur_sel cur_sel;
        t_step    step;
        t_wr_sel  wr_sel;
        logic     rd_pos;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     st_set;
        t_status  st;
        logic     cap_rd;
        logic     cap_found;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pos_gt;
        logic            pos_ge;
        logic            full;
        logic            ins_done;
        logic            walk_end;
        logic            match;
    } t_sts;

endpackage

### src/ale_if.sv
// ============================================================================
// ale_req_if / ale_rsp_if
// Valid/ready channels carrying request and result words of the list engine.
// ============================================================================
interface ale_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [6:0]  position;
    logic [31:0] item_value;

    modport source (output valid, output opcode, output position, output item_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input item_value,
                    output ready);
endinterface

interface ale_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [5:0]  found_position;
    logic [6:0]  count;

    modport source (output valid, output status, output read_value,
                    output found_position, output count, input ready);
    modport sink   (input valid, input status, input read_value,
                    input found_position, input count, output ready);
endinterface

### src/array_list_engine.sv
// ============================================================================
// array_list_engine
// Fixed-capacity ordered list of words with append/insert/remove/read/write/find.
// ============================================================================
// One request word in, one result word out. Entries live in a single RAM with
// one write and one registered read port, so insert, remove and find walk the
// list one entry per cycle: insert from the end down to position p, remove
// from p up to the end, find from the head up to the first match. Append,
// read, write and a rejected request load the result register without a
// walk. A new request is taken while the previous result still waits in the
// output register.
module array_list_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ale_req_if.sink   i_req,
    ale_rsp_if.source o_rsp
);
    import ale_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ale_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ale_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_opcode         (i_req.opcode),
        .i_position       (i_req.position),
        .i_item_value     (i_req.item_value),
        .o_status         (o_rsp.status),
        .o_read_value     (o_rsp.read_value),
        .o_found_position (o_rsp.found_position),
        .o_count          (o_rsp.count)
    );

endmodule

### src/ale_ram.sv
// ============================================================================
// ale_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/ale_datapath.sv
// ============================================================================
// ale_datapath
// Request registers, list length, walk cursor, entry RAM and result registers.
// ============================================================================
module ale_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ale_pkg::t_cmd                i_cmd,
    output ale_pkg::t_sts                o_sts,
    input  logic [ale_pkg::OP_W-1:0]     i_opcode,
    input  logic [ale_pkg::POS_W-1:0]    i_position,
    input  logic [ale_pkg::VAL_W-1:0]    i_item_value,
    output logic [ale_pkg::ST_W-1:0]     o_status,
    output logic [ale_pkg::VAL_W-1:0]    o_read_value,
    output logic [ale_pkg::FOUND_W-1:0]  o_found_position,
    output logic [ale_pkg::CNT_W-1:0]    o_count
);
    import ale_pkg::*;

    logic [OP_W-1:0]    r_op;
    logic [POS_W-1:0]   r_pos;
    logic [WIDTH-1:0]   r_val;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_cur, n_cur;
    logic [CNT_W-1:0]   r_wa, n_wa;
    logic               r_rvld, n_rvld;
    logic [ST_W-1:0]    r_status;
    logic [WIDTH-1:0]   r_rdv;
    logic [FOUND_W-1:0] r_found;

    logic [ST_W-1:0]    r_o_status;
    logic [VAL_W-1:0]   r_o_rdv;
    logic [FOUND_W-1:0] r_o_found;
    logic [CNT_W-1:0]   r_o_count;

    logic [CMP_W-1:0]   pos_c, cnt_c, cur_c;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [WIDTH-1:0]   ram_wdata, ram_rdata;

    assign pos_c = CMP_W'(r_pos);
    assign cnt_c = CMP_W'(r_count);
    assign cur_c = CMP_W'(r_cur);

    assign o_sts.op       = r_op;
    assign o_sts.pos_gt   = pos_c > cnt_c;
    assign o_sts.pos_ge   = pos_c >= cnt_c;
    assign o_sts.full     = r_count == CNT_W'(DEPTH);
    assign o_sts.ins_done = (cur_c == pos_c) && !r_rvld;
    assign o_sts.walk_end = (cur_c >= cnt_c) && !r_rvld;
    assign o_sts.match    = r_rvld && (ram_rdata == r_val);

    // cursor and read issue
    always_comb begin
        n_cur     = r_cur;
        n_wa      = r_wa;
        n_rvld    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_pos[ADDR_W-1:0];
        case (i_cmd.cur_sel)
            CUR_COUNT:   n_cur = r_count;
            CUR_POS_INC: n_cur = CNT_W'(r_pos) + CNT_W'(1);
            CUR_ZERO:    n_cur = '0;
            default:     ;
        endcase
        case (i_cmd.step)
            STEP_DOWN: begin
                if (cur_c > pos_c) begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(r_cur - CNT_W'(1));
                    n_cur     = r_cur - CNT_W'(1);
                    n_wa      = r_cur;
                    n_rvld    = 1'b1;
                end
            end
            STEP_UP: begin
                if (cur_c < cnt_c) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_cur[ADDR_W-1:0];
                    n_cur     = r_cur + CNT_W'(1);
                    n_wa      = r_cur - CNT_W'(1);
                    n_rvld    = 1'b1;
                end
            end
            STEP_SCAN: begin
                if (cur_c < cnt_c) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_cur[ADDR_W-1:0];
                    n_cur     = r_cur + CNT_W'(1);
                    n_wa      = r_cur;
                    n_rvld    = 1'b1;
                end
            end
            default: ;
        endcase
        if (i_cmd.rd_pos) begin
            ram_re    = 1'b1;
            ram_raddr = r_pos[ADDR_W-1:0];
        end
    end

    // write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos[ADDR_W-1:0];
        ram_wdata = r_val;
        case (i_cmd.wr_sel)
            WR_AT_COUNT: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[ADDR_W-1:0];
            end
            WR_AT_POS: begin
                ram_we    = 1'b1;
            end
            WR_SHIFT: begin
                ram_we    = r_rvld;
                ram_waddr = r_wa[ADDR_W-1:0];
                ram_wdata = ram_rdata;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rvld  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_rvld  <= n_rvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_wa  <= n_wa;
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_pos    <= i_position;
            r_val    <= i_item_value[WIDTH-1:0];
            r_status <= ST_OK;
            r_rdv    <= '0;
            r_found  <= '0;
        end else begin
            if (i_cmd.st_set) begin
                r_status <= i_cmd.st;
            end
            if (i_cmd.cap_rd) begin
                r_rdv <= ram_rdata;
            end
            if (i_cmd.cap_found) begin
                r_found <= FOUND_W'(r_wa);
            end
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_rdv    <= VAL_W'(r_rdv);
            r_o_found  <= r_found;
            r_o_count  <= r_count;
        end
    end

    ale_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_status         = r_o_status;
    assign o_read_value     = r_o_rdv;
    assign o_found_position = r_o_found;
    assign o_count          = r_o_count;

endmodule

### src/ale_ctrl.sv
// ============================================================================
// ale_ctrl
// Request sequencer: decodes the opcode, runs entry walks, hands off results.
// ============================================================================
module ale_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    input  ale_pkg::t_sts i_sts,
    output ale_pkg::t_cmd o_cmd
);
    import ale_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_INS    = 7'b0000100,
        S_REM    = 7'b0001000,
        S_FIND   = 7'b0010000,
        S_RDWAIT = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovld, n_ovld;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_ovld;

    always_comb begin
        n_state = r_state;
        n_ovld  = r_ovld && !i_rsp_ready;
        o_cmd   = '{load: 1'b0, cur_sel: CUR_HOLD, step: STEP_NONE, wr_sel: WR_NONE,
                    rd_pos: 1'b0, cnt_inc: 1'b0, cnt_dec: 1'b0, st_set: 1'b0,
                    st: ST_OK, cap_rd: 1'b0, cap_found: 1'b0, out_load: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_RESP;
                unique case (i_sts.op)
                    OP_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st     = ST_FULL;
                        end else begin
                            o_cmd.wr_sel  = WR_AT_COUNT;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        if (i_sts.pos_gt) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st     = ST_BADPOS;
                        end else if (i_sts.full) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st     = ST_FULL;
                        end else begin
                            o_cmd.cur_sel = CUR_COUNT;
                            n_state       = S_INS;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_sts.pos_ge) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st     = ST_BADPOS;
                        end else begin
                            o_cmd.cur_sel = CUR_POS_INC;
                            n_state       = S_REM;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.pos_ge) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st     = ST_BADPOS;
                        end else begin
                            o_cmd.rd_pos = 1'b1;
                            n_state      = S_RDWAIT;
                        end
                    end
                    OP_WRITE: begin
                        if (i_sts.pos_ge) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st     = ST_BADPOS;
                        end else begin
                            o_cmd.wr_sel = WR_AT_POS;
                        end
                    end
                    OP_FIND: begin
                        o_cmd.st_set  = 1'b1;
                        o_cmd.st      = ST_NOTFOUND;
                        o_cmd.cur_sel = CUR_ZERO;
                        n_state       = S_FIND;
                    end
                    default: ;
                endcase
            end
            S_INS: begin
                if (i_sts.ins_done) begin
                    o_cmd.wr_sel  = WR_AT_POS;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.step   = STEP_DOWN;
                    o_cmd.wr_sel = WR_SHIFT;
                end
            end
            S_REM: begin
                if (i_sts.walk_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.step   = STEP_UP;
                    o_cmd.wr_sel = WR_SHIFT;
                end
            end
            S_FIND: begin
                if (i_sts.match) begin
                    o_cmd.st_set    = 1'b1;
                    o_cmd.st        = ST_OK;
                    o_cmd.cap_found = 1'b1;
                    n_state         = S_RESP;
                end else if (i_sts.walk_end) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.step = STEP_SCAN;
                end
            end
            S_RDWAIT: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (!r_ovld || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovld         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

endmodule

### test/tb_array_list_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_array_list_engine
// Self-checking regression for the fixed-capacity list engine.
// ============================================================================
// First, a table of directed requests covers the empty list, the full list,
// the position limits, the spare opcodes and find hits and misses. Then
// random requests are grouped into grow, shrink, mixed and lookup phases, so
// the list fills up and drains again many times. A shadow copy of the list
// predicts every result word that no typed table row gives. The sender
// offers words in bursts. The receiver stalls on patterns of its own and
// twice holds off long enough to back the engine up into its request port.
module tb_array_list_engine;
    import ale_pkg::*;

    localparam logic [OP_W-1:0] OPC_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OPC_SPARE7 = 3'd7;

    localparam int RAND_ITEMS   = 1800;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam int LIMIT_CYCLES = 1_000_000;

    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;
    localparam int PH_LOOKUP = 3;

    localparam int RCV_ALWAYS  = 0;
    localparam int RCV_RANDOM  = 1;
    localparam int RCV_PATTERN = 2;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] item_value;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic [VAL_W-1:0]   read_value;
        logic [FOUND_W-1:0] found_position;
        logic [POS_W-1:0]   count;
    } t_result;

    typedef struct {
        logic [OP_W-1:0]    opcode;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   item_value;
        int                 reps;
        bit                 typed;
        t_status            status;
        logic [VAL_W-1:0]   read_value;
        logic [FOUND_W-1:0] found_position;
        logic [POS_W-1:0]   count;
    } t_dir_row;

    // reps > 1 repeats the row with item_value counting up
    t_dir_row directed_rows [27] = '{
        '{OP_READ,    7'd0,   32'h0000_0000, 1,  1'b1, ST_BADPOS,   32'h0, 6'd0, 7'd0},
        '{OP_REMOVE,  7'd0,   32'h0000_0000, 1,  1'b1, ST_BADPOS,   32'h0, 6'd0, 7'd0},
        '{OP_WRITE,   7'd0,   32'hffff_ffff, 1,  1'b1, ST_BADPOS,   32'h0, 6'd0, 7'd0},
        '{OP_FIND,    7'd0,   32'h0000_0000, 1,  1'b1, ST_NOTFOUND, 32'h0, 6'd0, 7'd0},
        '{OPC_SPARE6, 7'd0,   32'hffff_ffff, 1,  1'b1, ST_OK,       32'h0, 6'd0, 7'd0},
        '{OPC_SPARE7, 7'd127, 32'hffff_ffff, 1,  1'b1, ST_OK,       32'h0, 6'd0, 7'd0},
        '{OP_INSERT,  7'd1,   32'h0000_0001, 1,  1'b1, ST_BADPOS,   32'h0, 6'd0, 7'd0},
        '{OP_INSERT,  7'd0,   32'hffff_ffff, 1,  1'b1, ST_OK,       32'h0, 6'd0, 7'd1},
        '{OP_APPEND,  7'd127, 32'h0000_0000, 1,  1'b1, ST_OK,       32'h0, 6'd0, 7'd2},
        '{OP_READ,    7'd0,   32'h0000_0000, 1,  1'b1, ST_OK, 32'hffff_ffff, 6'd0, 7'd2},
        '{OP_READ,    7'd1,   32'hffff_ffff, 1,  1'b1, ST_OK,       32'h0, 6'd0, 7'd2},
        '{OP_FIND,    7'd0,   32'h0000_0000, 1,  1'b1, ST_OK,       32'h0, 6'd1, 7'd2},
        '{OP_WRITE,   7'd1,   32'ha5a5_a5a5, 1,  1'b1, ST_OK,       32'h0, 6'd0, 7'd2},
        '{OP_INSERT,  7'd2,   32'h5a5a_5a5a, 1,  1'b1, ST_OK,       32'h0, 6'd0, 7'd3},
        '{OP_INSERT,  7'd1,   32'h1234_5678, 1,  1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
        '{OP_APPEND,  7'd0,   32'h3000_0000, 60, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
        '{OP_APPEND,  7'd0,   32'h0000_0000, 1,  1'b1, ST_FULL,     32'h0, 6'd0, 7'd64},
        '{OP_INSERT,  7'd64,  32'h0000_0000, 1,  1'b1, ST_FULL,     32'h0, 6'd0, 7'd64},
        '{OP_INSERT,  7'd65,  32'h0000_0000, 1,  1'b1, ST_BADPOS,   32'h0, 6'd0, 7'd64},
        '{OP_INSERT,  7'd127, 32'h0000_0000, 1,  1'b1, ST_BADPOS,   32'h0, 6'd0, 7'd64},
        '{OP_READ,    7'd64,  32'h0000_0000, 1,  1'b1, ST_BADPOS,   32'h0, 6'd0, 7'd64},
        '{OP_FIND,    7'd0,   32'h3000_003b, 1,  1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
        '{OP_READ,    7'd63,  32'h0000_0000, 1,  1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
        '{OP_WRITE,   7'd63,  32'h0000_0000, 1,  1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
        '{OP_REMOVE,  7'd63,  32'h0000_0000, 1,  1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
        '{OP_REMOVE,  7'd0,   32'h0000_0000, 1,  1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
        '{OP_FIND,    7'd0,   32'hffff_ffff, 1,  1'b0, ST_OK,       32'h0, 6'd0, 7'd0}
    };

    logic [VAL_W-1:0] value_pool [8] = '{
        32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
        32'hdead_beef, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff
    };

    logic i_clk;
    logic i_rst_n;

    ale_req_if req_ch ();
    ale_rsp_if rsp_ch ();

    array_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic [VAL_W-1:0] shadow_list [DEPTH];
    int unsigned      shadow_len;
    t_result          pending_results [$];
    int unsigned      mismatches   = 0;
    int unsigned      cycle_count  = 0;
    int unsigned      hold_requests = 0;
    int unsigned      burst_left   = 0;
    bit               sender_gaps  = 1'b1;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("array_list_engine regression: fail");
            $finish;
        end
    end

    function automatic t_result apply_request(input t_request r);
        t_result res;
        res = '{status: ST_OK, read_value: '0, found_position: '0, count: '0};
        case (r.opcode)
            OP_APPEND: begin
                if (shadow_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_list[shadow_len] = r.item_value;
                    shadow_len++;
                end
            end
            OP_INSERT: begin
                if (r.position > shadow_len) begin
                    res.status = ST_BADPOS;
                end else if (shadow_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int unsigned j = shadow_len; j > r.position; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[r.position] = r.item_value;
                    shadow_len++;
                end
            end
            OP_REMOVE: begin
                if (r.position >= shadow_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int unsigned j = r.position; j + 1 < shadow_len; j++)
                        shadow_list[j] = shadow_list[j+1];
                    shadow_len--;
                end
            end
            OP_READ: begin
                if (r.position >= shadow_len)
                    res.status = ST_BADPOS;
                else
                    res.read_value = shadow_list[r.position];
            end
            OP_WRITE: begin
                if (r.position >= shadow_len)
                    res.status = ST_BADPOS;
                else
                    shadow_list[r.position] = r.item_value;
            end
            OP_FIND: begin
                res.status = ST_NOTFOUND;
                for (int unsigned j = 0; j < shadow_len; j++) begin
                    if (shadow_list[j] == r.item_value) begin
                        res.status = ST_OK;
                        res.found_position = FOUND_W'(j);
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.count = POS_W'(shadow_len);
        return res;
    endfunction

    // typed rows override the prediction; the shadow list is updated either way
    task automatic send_word(input t_request r, input bit typed, input t_result want);
        t_result res;
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= r.opcode;
        req_ch.position   <= r.position;
        req_ch.item_value <= r.item_value;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        res = apply_request(r);
        pending_results.push_back(typed ? want : res);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if (sender_gaps) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: status %0d count %0d",
                       rsp_ch.status, rsp_ch.count);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.read_value !== want.read_value) begin
                    $error("read_value: expected %08h, got %08h",
                           want.read_value, rsp_ch.read_value);
                    mismatches++;
                end
                if (rsp_ch.found_position !== want.found_position) begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, rsp_ch.found_position);
                    mismatches++;
                end
                if (rsp_ch.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int unsigned stall_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned hold_served;
        logic [15:0] stall_bits;
        rsp_ch.ready = 1'b0;
        stall_mode   = RCV_ALWAYS;
        mode_left    = 0;
        hold_left    = 0;
        hold_served  = 0;
        stall_bits   = '1;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(RCV_ALWAYS, RCV_PATTERN);
                mode_left  = $urandom_range(100, 600);
                stall_bits = 16'($urandom) | 16'h0001;
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    RCV_ALWAYS: rsp_ch.ready <= 1'b1;
                    RCV_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        rsp_ch.ready <= stall_bits[0];
                        stall_bits = {stall_bits[0], stall_bits[15:1]};
                    end
                endcase
            end
        end
    end

    initial begin
        t_request    r;
        t_result     want;
        int unsigned phase;
        int unsigned phase_left;
        int unsigned pick;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = '0;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        shadow_len        = 0;
        phase             = PH_MIXED;
        phase_left        = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            for (int k = 0; k < directed_rows[i].reps; k++) begin
                r.opcode     = directed_rows[i].opcode;
                r.position   = directed_rows[i].position;
                r.item_value = directed_rows[i].item_value + VAL_W'(k);
                want = '{status:         directed_rows[i].status,
                         read_value:     directed_rows[i].read_value,
                         found_position: directed_rows[i].found_position,
                         count:          directed_rows[i].count};
                send_word(r, directed_rows[i].typed, want);
            end
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 200 || n == 1200)
                hold_requests++;
            if (phase_left == 0) begin
                phase       = $urandom_range(PH_GROW, PH_LOOKUP);
                phase_left  = $urandom_range(60, 200);
                sender_gaps = ($urandom_range(0, 2) != 0);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            case (phase)
                PH_GROW:
                    r.opcode = (pick < 45) ? OP_APPEND :
                               (pick < 80) ? OP_INSERT : OP_W'($urandom_range(2, 5));
                PH_SHRINK:
                    r.opcode = (pick < 55) ? OP_REMOVE : OP_W'($urandom_range(0, 5));
                PH_LOOKUP:
                    r.opcode = (pick < 40) ? OP_FIND :
                               (pick < 70) ? OP_READ :
                               (pick < 90) ? OP_WRITE : OP_W'($urandom_range(0, 7));
                default:
                    r.opcode = (pick < 4) ? OP_W'($urandom_range(6, 7)) :
                                            OP_W'($urandom_range(0, 5));
            endcase
            r.position = ($urandom_range(0, 7) != 0) ? POS_W'($urandom_range(0, shadow_len))
                                                     : POS_W'($urandom_range(0, 127));
            if (r.opcode == OP_FIND && shadow_len != 0 && $urandom_range(0, 9) < 7)
                r.item_value = shadow_list[$urandom_range(0, shadow_len - 1)];
            else if ($urandom_range(0, 1) != 0)
                r.item_value = value_pool[$urandom_range(0, 7)];
            else
                r.item_value = $urandom;
            send_word(r, 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("array_list_engine regression: pass");
        else
            $display("array_list_engine regression: fail");
        $finish;
    end

endmodule
